// ===== design/brb_pkg.sv =====
package brb_pkg;

  // Field widths of the stream words and the configuration register.
  localparam int DATA_W  = 8;
  localparam int COUNT_W = 13;
  localparam int MODE_W  = 2;

  // Packed widths, rounded up to whole bytes.
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 64;

  // Configuration register map.
  localparam int          PADDR_W            = 3;
  localparam logic [2:0]  ADDR_USED_SIZE     = 3'd0;
  localparam logic [12:0] USED_SIZE_RESET    = 13'd4096;
  localparam logic [12:0] USED_SIZE_MIN      = 13'd2;

  // Item kinds carried on the input tuser.
  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE   = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_QUERY   = 2'd2
  } mode_t;

endpackage

// ===== design/byte_ring_buffer_with_blocks_core.sv =====
// A word accepted on the input is held in the input register, executed from
// there once the result register is free; the result register offers its word.
// Throughput: one word per cycle while the output side takes each result word;
// the index update and the one write and one read port of the byte store set it.
// Reset (synchronous, rst high): indices zero, ring empty, used size 4096,
// both stages empty. The byte store is not cleared and needs no clearing pass.
module byte_ring_buffer_with_blocks_core #(
  parameter int DEPTH = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  // Input stream.
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // tdata, lowest bit up: data[7:0], length[20:8], threshold[33:21], zero pad.
  input  logic [brb_pkg::S_TDATA_W-1:0]   s_tdata,
  // tuser: mode[1:0].
  input  logic [brb_pkg::MODE_W-1:0]      s_tuser,
  // Output stream.
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // tdata, lowest bit up: read_data[7:0], readable[20:8], readable_block[33:21],
  // writable[46:34], writable_block[59:47], empty_flag[60], full_flag[61],
  // error[62], zero pad.
  output logic [brb_pkg::M_TDATA_W-1:0]   m_tdata,
  // Configuration port.
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [brb_pkg::PADDR_W-1:0]     paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import brb_pkg::*;

  // Index width follows the store depth. Counts are worked in SW bits, wide
  // enough for both the ring size and the 13-bit fields; sums need one more.
  localparam int IW = $clog2(DEPTH);
  localparam int SW = (IW >= COUNT_W) ? IW + 1 : COUNT_W;

  // ---------------------------------------------------------------------------
  // Configuration register. A write restarts the ring and wins over the datapath;
  // the user must write only while idle; the block itself does not enforce this.
  // ---------------------------------------------------------------------------
  logic [COUNT_W-1:0] used_size;
  logic               cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr == ADDR_USED_SIZE);
  assign prdata    = (paddr == ADDR_USED_SIZE) ? {{(32-COUNT_W){1'b0}}, used_size} : '0;

  // Effective ring size: the register clamped to 2..DEPTH.
  logic [SW-1:0] ring_n;
  always_comb begin
    if (used_size < USED_SIZE_MIN) begin
      ring_n = SW'(USED_SIZE_MIN);
    end else if (SW'(used_size) > SW'(DEPTH)) begin
      ring_n = SW'(DEPTH);
    end else begin
      ring_n = SW'(used_size);
    end
  end

  // ---------------------------------------------------------------------------
  // Input register. It loads whenever it is empty or its word moves on.
  // ---------------------------------------------------------------------------
  logic               in_valid;
  logic [1:0]         in_mode;
  logic [DATA_W-1:0]  in_data;
  logic [COUNT_W-1:0] in_length;
  logic [COUNT_W-1:0] in_threshold;

  logic out_valid;
  logic advance;

  // The word in the input register is processed when the result register is
  // free or is being emptied in this cycle.
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_mode      <= s_tuser;
      in_data      <= s_tdata[7:0];
      in_length    <= s_tdata[20:8];
      in_threshold <= s_tdata[33:21];
    end
  end

  // ---------------------------------------------------------------------------
  // Ring state.
  // ---------------------------------------------------------------------------
  logic [IW-1:0] read_index,  read_index_next;
  logic [IW-1:0] write_index, write_index_next;
  logic          empty_mark,  empty_mark_next;
  logic          full_mark,   full_mark_next;

  // Counts before the item, used to judge whether it is refused.
  logic [SW-1:0] rd_before;
  logic [SW-1:0] wr_before;
  logic          same_before;

  always_comb begin
    same_before = (read_index == write_index);
    if (same_before && empty_mark) begin
      rd_before = '0;
    end else if (write_index > read_index) begin
      rd_before = SW'(write_index) - SW'(read_index);
    end else begin
      rd_before = ring_n - SW'(read_index) + SW'(write_index);
    end
    if (same_before && full_mark) begin
      wr_before = '0;
    end else if (read_index > write_index) begin
      wr_before = SW'(read_index) - SW'(write_index);
    end else begin
      wr_before = ring_n - SW'(write_index) + SW'(read_index);
    end
  end

  // Item execution. A write appends at the write index and advances it; a
  // release moves the read index on by the length, wrapping once at most since
  // the length never exceeds what is readable.
  logic              mem_we;
  logic              item_error;
  logic [IW:0]       write_step;
  logic [SW:0]       release_sum;

  always_comb begin
    read_index_next  = read_index;
    write_index_next = write_index;
    empty_mark_next  = empty_mark;
    full_mark_next   = full_mark;
    mem_we           = 1'b0;
    item_error       = 1'b0;
    write_step       = {1'b0, write_index} + 1'b1;
    release_sum      = (SW+1)'(read_index) + (SW+1)'(in_length);
    case (mode_t'(in_mode))
      MODE_WRITE: begin
        if (wr_before == '0) begin
          item_error = 1'b1;
        end else begin
          mem_we = 1'b1;
          if ((SW+1)'(write_step) >= (SW+1)'(ring_n)) begin
            write_index_next = '0;
          end else begin
            write_index_next = write_step[IW-1:0];
          end
          empty_mark_next = 1'b0;
          full_mark_next  = (write_index_next == read_index);
        end
      end
      MODE_RELEASE: begin
        if (SW'(in_length) > rd_before) begin
          item_error = 1'b1;
        end else if (in_length != '0) begin
          if (release_sum >= (SW+1)'(ring_n)) begin
            read_index_next = IW'(release_sum - (SW+1)'(ring_n));
          end else begin
            read_index_next = IW'(release_sum);
          end
          full_mark_next  = 1'b0;
          empty_mark_next = (read_index_next == write_index);
        end
      end
      default: begin
        // A query, and the unused fourth code, change nothing.
      end
    endcase
  end

  // Counts after the item, as reported in the result word.
  logic [SW-1:0] rd_after, rdb_after, wr_after, wrb_after;
  logic          same_after;

  always_comb begin
    same_after = (read_index_next == write_index_next);
    if (same_after && empty_mark_next) begin
      rd_after  = '0;
      rdb_after = '0;
    end else if (write_index_next > read_index_next) begin
      rd_after  = SW'(write_index_next) - SW'(read_index_next);
      rdb_after = rd_after;
    end else begin
      rdb_after = ring_n - SW'(read_index_next);
      rd_after  = rdb_after + SW'(write_index_next);
    end
    if (same_after && full_mark_next) begin
      wr_after  = '0;
      wrb_after = '0;
    end else if (read_index_next > write_index_next) begin
      wr_after  = SW'(read_index_next) - SW'(write_index_next);
      wrb_after = wr_after;
    end else begin
      wrb_after = ring_n - SW'(write_index_next);
      wr_after  = wrb_after + SW'(read_index_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_size   <= USED_SIZE_RESET;
      read_index  <= '0;
      write_index <= '0;
      empty_mark  <= 1'b1;
      full_mark   <= 1'b0;
    end else if (cfg_write) begin
      used_size   <= pwdata[COUNT_W-1:0];
      read_index  <= '0;
      write_index <= '0;
      empty_mark  <= 1'b1;
      full_mark   <= 1'b0;
    end else if (advance) begin
      read_index  <= read_index_next;
      write_index <= write_index_next;
      empty_mark  <= empty_mark_next;
      full_mark   <= full_mark_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Byte store. It is read at the new read index in the same cycle as the
  // item is executed; when the write lands on that very entry (a write into an
  // empty ring) the new byte is passed straight through.
  // ---------------------------------------------------------------------------
  logic [DATA_W-1:0] byte_store [DEPTH];
  logic [DATA_W-1:0] store_rdata;

  always_ff @(posedge clk) begin
    if (advance && mem_we) begin
      byte_store[write_index] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (mem_we && (write_index == read_index_next)) begin
        store_rdata <= in_data;
      end else begin
        store_rdata <= byte_store[read_index_next];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register. It holds its word until the output side takes it.
  // ---------------------------------------------------------------------------
  logic               out_has_data;
  logic [COUNT_W-1:0] out_readable;
  logic [COUNT_W-1:0] out_readable_block;
  logic [COUNT_W-1:0] out_writable;
  logic [COUNT_W-1:0] out_writable_block;
  logic               out_empty;
  logic               out_full;
  logic               out_error;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_has_data       <= (rd_after != '0);
      out_readable       <= rd_after[COUNT_W-1:0];
      out_readable_block <= rdb_after[COUNT_W-1:0];
      out_writable       <= wr_after[COUNT_W-1:0];
      out_writable_block <= wrb_after[COUNT_W-1:0];
      out_empty          <= (rd_after <= SW'(in_threshold));
      out_full           <= (wr_after <= SW'(in_threshold));
      out_error          <= item_error;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_error, out_full, out_empty,
                     out_writable_block, out_writable,
                     out_readable_block, out_readable,
                     out_has_data ? store_rdata : {DATA_W{1'b0}}};

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_marks_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(empty_mark && full_mark))
    else $error("empty and full marks set together");

  a_marks_need_equal: assert property (@(posedge clk) disable iff (rst)
    (empty_mark || full_mark) |-> (read_index == write_index))
    else $error("ring mark set with unequal indices");

  a_indices_in_ring: assert property (@(posedge clk) disable iff (rst)
    (SW'(read_index) < ring_n) && (SW'(write_index) < ring_n))
    else $error("ring index beyond the used size");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (rst)
    (in_valid && out_valid && !m_tready && !cfg_write) |=>
      ($stable(read_index) && $stable(write_index)))
    else $error("ring state moved while the result was stalled");

endmodule
